@@ design/rmlp_pkg.sv @@
// Package for the reverse-map list pool: widths, entry layout, codes and
// the control structs passed between the core and its memory and free map.
// No dependencies.
package rmlp_pkg;

  // Pool geometry
  localparam int SLOTS            = 256;
  localparam int IDX_W            = 8;
  localparam int LIM_W            = 9;
  localparam int STEP_W           = 9;   // top bit set means the walk bound is reached
  localparam int FREE_WORD_W      = 8;
  localparam int BIT_SEL_W        = 3;
  localparam int FREE_WORDS       = SLOTS / FREE_WORD_W;
  localparam int WORD_IDX_W       = IDX_W - BIT_SEL_W;
  localparam int POOL_ENTRIES_DEF = 256;
  localparam logic [LIM_W-1:0] CFG_RESET = 9'd256;

  typedef enum logic {
    OP_ATTACH = 1'b0,
    OP_DETACH = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOTFOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ALLOC,
    S_A_RD,
    S_A_WALK,
    S_D_WALK,
    S_D_FREE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [31:0]      addr;
    logic [15:0]      owner;
    logic [IDX_W-1:0] next;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic             take;
    logic             release_en;
    logic [IDX_W-1:0] idx;
  } fmap_cmd_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
    logic             last;
  } fmap_scan_t;

endpackage

@@ design/rmlp_entry_mem.sv @@
// Entry store of the reverse-map pool: one write port, one read port,
// registered read data. Depends on rmlp_pkg.
module rmlp_entry_mem import rmlp_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rdata
);

  entry_t mem [SLOTS];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ design/rmlp_free_map.sv @@
// Free map of the pool: one flop per entry, scanned one 8-entry word per
// cycle for the lowest free entry below the limit. Depends on rmlp_pkg.
module rmlp_free_map import rmlp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fmap_cmd_t             cmd,
  input  logic [WORD_IDX_W-1:0] scan_word,
  input  logic [LIM_W-1:0]      lim,
  output fmap_scan_t            scan
);

  logic [FREE_WORD_W-1:0] free_r [FREE_WORDS];

  // free bits: entry 0 is never free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < FREE_WORDS; w++) begin
        free_r[w] <= '1;
      end
      free_r[0][0] <= 1'b0;
    end else if (cmd.take) begin
      free_r[cmd.idx[IDX_W-1:BIT_SEL_W]][cmd.idx[BIT_SEL_W-1:0]] <= 1'b0;
    end else if (cmd.release_en) begin
      free_r[cmd.idx[IDX_W-1:BIT_SEL_W]][cmd.idx[BIT_SEL_W-1:0]] <= 1'b1;
    end
  end

  // mask one word against the limit and pick the lowest free bit
  always_comb begin
    logic [FREE_WORD_W-1:0] avail;
    logic [IDX_W-1:0]       cand;
    logic [LIM_W-1:0]       next_base;
    for (int b = 0; b < FREE_WORD_W; b++) begin
      cand     = {scan_word, BIT_SEL_W'(b)};
      avail[b] = free_r[scan_word][b] && (cand != '0) && ({1'b0, cand} < lim);
    end
    scan.hit = |avail;
    scan.idx = '0;
    for (int b = FREE_WORD_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        scan.idx = {scan_word, BIT_SEL_W'(b)};
      end
    end
    next_base = (LIM_W'(scan_word) + LIM_W'(1)) << BIT_SEL_W;
    scan.last = (next_base >= lim);
  end

endmodule

@@ design/reverse_map_list_pool_core.sv @@
// Reverse-map list pool core. One item at a time; a result register lets the
// next item enter the cycle after the previous result is loaded, while it waits.
// Attach: scans 1..32 free-map words, writes the new entry, then walks the list to the tail;
//   an empty head skips the walk, and a full pool answers after the scan.
// Detach: walks the list to a match and frees it, or to the end with no match.
// Reset: synchronous; free map set, entry store left unwritten.
module reverse_map_list_pool_core import rmlp_pkg::*; #(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [LIM_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_op,
  input  logic [IDX_W-1:0]  in_head_in,
  input  logic [31:0]       in_pte_addr,
  input  logic [15:0]       in_owner,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [IDX_W-1:0]  out_entry_index,
  output logic [IDX_W-1:0]  out_head_out,
  output logic signed [1:0] out_ref_change
);

  localparam logic [LIM_W-1:0] POOL_CAP =
    (POOL_ENTRIES > SLOTS) ? LIM_W'(SLOTS) : LIM_W'(POOL_ENTRIES);

  state_t state_r, state_nxt;
  logic [LIM_W-1:0] cfg_r;
  logic [LIM_W-1:0] lim;

  // item registers
  op_t                   op_r, op_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [31:0]           addr_r, addr_nxt;
  logic [15:0]           own_r, own_nxt;
  logic [IDX_W-1:0]      cur_r, cur_nxt;
  logic [IDX_W-1:0]      prev_r, prev_nxt;
  entry_t                prev_ent_r, prev_ent_nxt;
  logic [STEP_W-1:0]     steps_r, steps_nxt;
  logic [STEP_W-1:0]     steps_inc;
  logic [IDX_W-1:0]      n_r, n_nxt;
  logic [WORD_IDX_W-1:0] scan_w_r, scan_w_nxt;

  // result being built
  status_t           res_status_r, res_status_nxt;
  logic [IDX_W-1:0]  res_idx_r, res_idx_nxt;
  logic [IDX_W-1:0]  res_head_r, res_head_nxt;
  logic signed [1:0] res_ref_r, res_ref_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [IDX_W-1:0]  out_head_r, out_head_nxt;
  logic signed [1:0] out_ref_r, out_ref_nxt;

  mem_req_t   mem_req;
  entry_t     rdata;
  fmap_cmd_t  fm_cmd;
  fmap_scan_t fm_scan;
  logic       in_acc;
  logic       out_free;
  logic       match;

  rmlp_entry_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  rmlp_free_map u_fmap (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (fm_cmd),
    .scan_word (scan_w_r),
    .lim       (lim),
    .scan      (fm_scan)
  );

  // usable limit
  assign lim       = (cfg_r > POOL_CAP) ? POOL_CAP : cfg_r;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign steps_inc = steps_r + STEP_W'(1);
  assign match     = (rdata.addr == addr_r) && (rdata.owner == own_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (op_t'(in_op) == OP_ATTACH) begin
            state_nxt = S_SCAN;
          end else if (in_head_in == '0) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_D_WALK;
          end
        end
      end
      S_SCAN: begin
        if (fm_scan.hit) begin
          state_nxt = S_ALLOC;
        end else if (fm_scan.last) begin
          state_nxt = S_RESP;
        end
      end
      S_ALLOC: begin
        state_nxt = (head_r == '0) ? S_RESP : S_A_RD;
      end
      S_A_RD: begin
        state_nxt = S_A_WALK;
      end
      S_A_WALK: begin
        if (!((rdata.next != '0) && !steps_r[STEP_W-1])) begin
          state_nxt = S_RESP;
        end
      end
      S_D_WALK: begin
        if (match) begin
          state_nxt = S_D_FREE;
        end else if (!((rdata.next != '0) && !steps_inc[STEP_W-1])) begin
          state_nxt = S_RESP;
        end
      end
      S_D_FREE: begin
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory and free-map commands
  always_comb begin
    op_nxt         = op_r;
    head_nxt       = head_r;
    addr_nxt       = addr_r;
    own_nxt        = own_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    prev_ent_nxt   = prev_ent_r;
    steps_nxt      = steps_r;
    n_nxt          = n_r;
    scan_w_nxt     = scan_w_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_head_nxt   = res_head_r;
    res_ref_nxt    = res_ref_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_head_nxt   = out_head_r;
    out_ref_nxt    = out_ref_r;
    mem_req        = '0;
    fm_cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt       = op_t'(in_op);
          head_nxt     = in_head_in;
          addr_nxt     = in_pte_addr;
          own_nxt      = in_owner;
          cur_nxt      = in_head_in;
          prev_nxt     = '0;
          steps_nxt    = '0;
          scan_w_nxt   = '0;
          // error result by default, overwritten on success
          res_status_nxt = (op_t'(in_op) == OP_ATTACH) ? STAT_FULL : STAT_NOTFOUND;
          res_idx_nxt    = '0;
          res_head_nxt   = in_head_in;
          res_ref_nxt    = 2'sd0;
          if ((op_t'(in_op) == OP_DETACH) && (in_head_in != '0)) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = in_head_in;
          end
        end
      end
      S_SCAN: begin
        if (fm_scan.hit) begin
          fm_cmd.take = 1'b1;
          fm_cmd.idx  = fm_scan.idx;
          n_nxt       = fm_scan.idx;
        end else begin
          scan_w_nxt = scan_w_r + WORD_IDX_W'(1);
        end
      end
      S_ALLOC: begin
        // new entry goes in before the tail walk
        mem_req.we          = 1'b1;
        mem_req.waddr       = n_r;
        mem_req.wdata.addr  = addr_r;
        mem_req.wdata.owner = own_r;
        mem_req.wdata.next  = '0;
        res_status_nxt      = STAT_DONE;
        res_idx_nxt         = n_r;
        res_ref_nxt         = 2'sd1;
        if (head_r == '0) begin
          res_head_nxt = n_r;
        end
      end
      S_A_RD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = head_r;
        cur_nxt       = head_r;
      end
      S_A_WALK: begin
        if ((rdata.next != '0) && !steps_r[STEP_W-1]) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = rdata.next;
          cur_nxt       = rdata.next;
          steps_nxt     = steps_inc;
        end else begin
          // link the new entry after the last node visited
          mem_req.we          = 1'b1;
          mem_req.waddr       = cur_r;
          mem_req.wdata.addr  = rdata.addr;
          mem_req.wdata.owner = rdata.owner;
          mem_req.wdata.next  = n_r;
        end
      end
      S_D_WALK: begin
        if (match) begin
          if (prev_r == '0) begin
            res_head_nxt = rdata.next;
          end else begin
            mem_req.we          = 1'b1;
            mem_req.waddr       = prev_r;
            mem_req.wdata.addr  = prev_ent_r.addr;
            mem_req.wdata.owner = prev_ent_r.owner;
            mem_req.wdata.next  = rdata.next;
          end
        end else begin
          prev_nxt     = cur_r;
          prev_ent_nxt = rdata;
          cur_nxt      = rdata.next;
          steps_nxt    = steps_inc;
          if ((rdata.next != '0) && !steps_inc[STEP_W-1]) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = rdata.next;
          end
        end
      end
      S_D_FREE: begin
        // clear and release the matched entry
        mem_req.we        = 1'b1;
        mem_req.waddr     = cur_r;
        mem_req.wdata     = '0;
        fm_cmd.release_en = 1'b1;
        fm_cmd.idx        = cur_r;
        res_status_nxt    = STAT_DONE;
        res_idx_nxt       = cur_r;
        res_ref_nxt       = -2'sd1;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_r;
          out_head_nxt   = res_head_r;
          out_ref_nxt    = res_ref_r;
        end
      end
      default: begin
        mem_req = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cfg_r       <= CFG_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    head_r       <= head_nxt;
    addr_r       <= addr_nxt;
    own_r        <= own_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    prev_ent_r   <= prev_ent_nxt;
    steps_r      <= steps_nxt;
    n_r          <= n_nxt;
    scan_w_r     <= scan_w_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_head_r   <= res_head_nxt;
    res_ref_r    <= res_ref_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_head_r   <= out_head_nxt;
    out_ref_r    <= out_ref_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_index = out_idx_r;
  assign out_head_out    = out_head_r;
  assign out_ref_change  = out_ref_r;

  // an accepted item always leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE))
    else $error("accepted item did not start work");

  // allocation never hands out entry 0 or an entry beyond the limit
  a_take_range: assert property (@(posedge clk) disable iff (!rst_n)
    fm_cmd.take |-> ((fm_cmd.idx != '0) && ({1'b0, fm_cmd.idx} < lim)))
    else $error("free map take out of range");

  // error results carry no entry and no reference change
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != STAT_DONE)) |->
      ((out_idx_r == '0) && (out_ref_r == 2'sd0)))
    else $error("error result with entry or reference change");

  // a successful result names a real entry
  a_done_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == STAT_DONE)) |-> (out_idx_r != '0))
    else $error("done result with entry 0");

endmodule

@@ test/rmap_checker.sv @@
// Result checker for the reverse-map list pool core: watches both item channels
// and the limit register port, predicts each result and compares it field by field.
// Depends on rmlp_pkg for widths, op and status codes.
module rmap_checker import rmlp_pkg::*; #(
  parameter int POOL_ENTRIES = POOL_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [LIM_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_op,
  input  logic [IDX_W-1:0]  in_head_in,
  input  logic [31:0]       in_pte_addr,
  input  logic [15:0]       in_owner,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        out_status,
  input  logic [IDX_W-1:0]  out_entry_index,
  input  logic [IDX_W-1:0]  out_head_out,
  input  logic signed [1:0] out_ref_change,
  input  logic              end_req,
  output int unsigned       fail_cnt
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] head;
    logic [1:0]       refc;
  } rmap_result_t;

  // Shadow copy of the pool: entry fields, free map and the limit register
  logic [31:0]      pte_of   [SLOTS];
  logic [15:0]      owner_of [SLOTS];
  logic [IDX_W-1:0] next_of  [SLOTS];
  bit               taken    [SLOTS];
  logic [LIM_W-1:0] pool_limit;

  rmap_result_t     mapping_q[$];
  rmap_result_t     want;
  bit               end_seen;

  task automatic pool_reset();
    for (int i = 0; i < SLOTS; i++) begin
      pte_of[i]   = '0;
      owner_of[i] = '0;
      next_of[i]  = '0;
      taken[i]    = 1'b0;
    end
    taken[0]   = 1'b1;
    pool_limit = CFG_RESET;
  endtask

  // Apply one request to the shadow pool and return the result it must give
  function automatic rmap_result_t predict_mapping(input op_t op, input logic [IDX_W-1:0] head,
                                                   input logic [31:0] addr,
                                                   input logic [15:0] own);
    rmap_result_t r;
    int lim, n, cur, prev, steps;
    bit found;
    r.status = STAT_DONE;
    r.idx    = '0;
    r.head   = head;
    r.refc   = 2'b00;
    if (op == OP_ATTACH) begin
      lim = pool_limit;
      if (lim > POOL_ENTRIES) lim = POOL_ENTRIES;
      if (lim > SLOTS) lim = SLOTS;
      // lowest free entry under the limit
      n = 0;
      for (int i = 1; i < lim; i++) begin
        if (n == 0 && !taken[i]) n = i;
      end
      if (n == 0) begin
        r.status = STAT_FULL;
      end else begin
        taken[n]    = 1'b1;
        pte_of[n]   = addr;
        owner_of[n] = own;
        next_of[n]  = '0;
        if (head == '0) begin
          r.head = IDX_W'(n);
        end else begin
          // walk to the tail, bounded so a looped list still ends
          cur   = head;
          steps = 0;
          while (next_of[cur] != '0 && steps < SLOTS) begin
            cur = next_of[cur];
            steps++;
          end
          next_of[cur] = IDX_W'(n);
        end
        r.idx  = IDX_W'(n);
        r.refc = 2'b01;
      end
    end else begin
      cur   = head;
      prev  = 0;
      steps = 0;
      found = 1'b0;
      while (cur != 0 && steps < SLOTS && !found) begin
        if (pte_of[cur] == addr && owner_of[cur] == own) begin
          found = 1'b1;
        end else begin
          prev = cur;
          cur  = next_of[cur];
          steps++;
        end
      end
      if (found) begin
        if (prev == 0) r.head = next_of[cur];
        else next_of[prev] = next_of[cur];
        // freed entry goes back cleared
        taken[cur]    = 1'b0;
        pte_of[cur]   = '0;
        owner_of[cur] = '0;
        next_of[cur]  = '0;
        r.idx  = IDX_W'(cur);
        r.refc = 2'b11;
      end else begin
        r.status = STAT_NOTFOUND;
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] exp_val,
                             input logic signed [31:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      fail_cnt++;
    end
  endtask

  // Register writes, result compare, then prediction of a newly accepted item
  always @(posedge clk) begin
    if (!rst_n) begin
      pool_reset();
      mapping_q.delete();
      fail_cnt = 0;
      end_seen = 1'b0;
    end else begin
      if (cfg_we) pool_limit = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (mapping_q.size() == 0) begin
          $error("result item with nothing pending: status %0d, entry %0d",
                 out_status, out_entry_index);
          fail_cnt++;
        end else begin
          want = mapping_q.pop_front();
          check_field("status", want.status, out_status);
          check_field("entry_index", want.idx, out_entry_index);
          check_field("head_out", want.head, out_head_out);
          check_field("ref_change", $signed(want.refc), out_ref_change);
        end
      end
      if (in_valid && !in_stall) begin
        mapping_q.push_back(predict_mapping(op_t'(in_op), in_head_in, in_pte_addr, in_owner));
      end
      if (end_req && !end_seen) begin
        end_seen = 1'b1;
        if (mapping_q.size() != 0) begin
          $error("%0d results never came out", mapping_q.size());
          fail_cnt += mapping_q.size();
        end
      end
    end
  end

endmodule

@@ test/tb_top.sv @@
// Testbench top for the reverse-map list pool core: clock, reset, limit register
// writes, request items and result back-pressure, plus the final verdict.
// Depends on rmlp_pkg, reverse_map_list_pool_core and rmap_checker.
module tb_top import rmlp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF   = 2;
  localparam int NPAGE      = 8;     // pages whose list heads we track
  localparam int IDLE_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int SETTLE     = 4;
  localparam int TAIL       = 20;
  localparam int NPHASE     = 10;
  localparam int CFG_RANDOM = -1;
  localparam int PH_CFG    [NPHASE] = '{256, 2, 0, 1, 511, 3, 300, 40, CFG_RANDOM, 256};
  localparam int PH_ITEMS  [NPHASE] = '{300, 40, 30, 30, 450, 40, 250, 150, 100, 60};
  localparam int PH_ATTACH [NPHASE] = '{55, 50, 60, 60, 80, 40, 25, 50, 50, 50};

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_we      = 1'b0;
  logic [LIM_W-1:0]  cfg_wdata   = '0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  logic              in_op       = 1'b0;
  logic [IDX_W-1:0]  in_head_in  = '0;
  logic [31:0]       in_pte_addr = '0;
  logic [15:0]       in_owner    = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  logic [1:0]        out_status;
  logic [IDX_W-1:0]  out_entry_index;
  logic [IDX_W-1:0]  out_head_out;
  logic signed [1:0] out_ref_change;
  logic              end_req     = 1'b0;
  int unsigned       fail_cnt;

  // Requests in flight, tagged with their page (NPAGE = not tied to a page)
  typedef struct {
    int          pg;
    logic [31:0] addr;
    logic [15:0] own;
  } mapping_req_t;

  mapping_req_t     inflight_q[$];
  mapping_req_t     done_req;
  int               pend      [NPAGE];
  logic [IDX_W-1:0] page_head [NPAGE];
  bit               written   [SLOTS];  // entries the block has stored at least once
  bit   [31:0]      ent_addr  [SLOTS];
  bit   [15:0]      ent_owner [SLOTS];
  int               ent_page  [SLOTS];
  bit               quiet;
  int               stall_left;
  int               idle_cycles;

  always #(CLK_HALF) clk = ~clk;

  reverse_map_list_pool_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_head_in      (in_head_in),
    .in_pte_addr     (in_pte_addr),
    .in_owner        (in_owner),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_head_out    (out_head_out),
    .out_ref_change  (out_ref_change)
  );

  rmap_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_head_in      (in_head_in),
    .in_pte_addr     (in_pte_addr),
    .in_owner        (in_owner),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_entry_index (out_entry_index),
    .out_head_out    (out_head_out),
    .out_ref_change  (out_ref_change),
    .end_req         (end_req),
    .fail_cnt        (fail_cnt)
  );

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'($urandom_range(0, 3));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_owner();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 16'($urandom_range(0, 3));
      default: return 16'($urandom());
    endcase
  endfunction

  // A head that only leads through entries already stored, or 0
  function automatic logic [IDX_W-1:0] pick_written();
    int k;
    for (int t = 0; t < 16; t++) begin
      k = $urandom_range(1, SLOTS - 1);
      if (written[k]) return IDX_W'(k);
    end
    return '0;
  endfunction

  // Send one request item, with a random gap before it
  task automatic issue(input op_t op, input logic [IDX_W-1:0] head, input logic [31:0] addr,
                       input logic [15:0] own, input int pg);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_head_in  <= head;
    in_pte_addr <= addr;
    in_owner    <= own;
    if (pg < NPAGE) pend[pg]++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    inflight_q.push_back('{pg, addr, own});
  endtask

  // Hold off the sender until every result is back
  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (inflight_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed attach/detach on tracked pages, some noise on any stored head
  task automatic random_item(input int attach_pct);
    int          pg, pick;
    int          cand[$];
    logic [31:0] addr;
    logic [15:0] own;
    op_t         op;
    pg = $urandom_range(0, NPAGE - 1);
    for (int t = 0; t < NPAGE && pend[pg] != 0; t++) pg = (pg + 1) % NPAGE;
    if (pend[pg] != 0) pg = NPAGE;
    addr = pick_addr();
    own  = pick_owner();
    if (pg == NPAGE || $urandom_range(0, 99) < 10) begin
      op = $urandom_range(0, 1) ? OP_DETACH : OP_ATTACH;
      if (op == OP_DETACH && $urandom_range(0, 1)) begin
        pick = pick_written();
        addr = ent_addr[pick];
        own  = ent_owner[pick];
      end
      issue(op, pick_written(), addr, own, NPAGE);
    end else if ($urandom_range(0, 99) < attach_pct) begin
      issue(OP_ATTACH, page_head[pg], addr, own, pg);
    end else begin
      for (int i = 1; i < SLOTS; i++) begin
        if (ent_page[i] == pg) cand.push_back(i);
      end
      if (cand.size() != 0) begin
        pick = cand[$urandom_range(0, cand.size() - 1)];
        addr = ent_addr[pick];
        own  = ent_owner[pick];
        // near miss: one of the two keys off by a bit
        if ($urandom_range(0, 99) < 15) begin
          if ($urandom_range(0, 1)) addr[0] = ~addr[0];
          else own[0] = ~own[0];
        end
      end
      issue(OP_DETACH, page_head[pg], addr, own, pg);
    end
  endtask

  // Result side: random stall per item and tracking of heads and stored entries
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall) begin
      if (inflight_q.size() != 0) begin
        done_req = inflight_q.pop_front();
        if (out_status == STAT_DONE && out_ref_change == 2'sd1) begin
          written[out_entry_index]   = 1'b1;
          ent_addr[out_entry_index]  = done_req.addr;
          ent_owner[out_entry_index] = done_req.own;
          ent_page[out_entry_index]  = done_req.pg;
        end else if (out_status == STAT_DONE) begin
          ent_page[out_entry_index] = NPAGE;
        end
        if (done_req.pg < NPAGE) begin
          pend[done_req.pg]--;
          if (out_head_out == '0 || written[out_head_out]) page_head[done_req.pg] = out_head_out;
        end
      end
      stall_left = quiet ? 0 : $urandom_range(0, 4);
      out_stall <= (stall_left != 0);
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[reverse_map_list_pool_core] ERROR");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) ent_page[i] = NPAGE;
    for (int p = 0; p < NPAGE; p++) page_head[p] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_limit(9'd256);

    // Directed: empty head, extreme keys, partial matches, head and tail unlink
    issue(OP_DETACH, 8'd0, 32'h0000_0001, 16'h0001, NPAGE);      // empty list
    issue(OP_ATTACH, 8'd0, 32'h0000_0000, 16'h0000, 0);          // entry 1
    issue(OP_ATTACH, 8'd1, 32'hFFFF_FFFF, 16'hFFFF, 0);          // entry 2 behind 1
    issue(OP_ATTACH, 8'd0, 32'hAAAA_AAAA, 16'h5555, 1);          // entry 3
    issue(OP_DETACH, 8'd1, 32'hFFFF_FFFF, 16'h0000, NPAGE);      // address only
    issue(OP_DETACH, 8'd1, 32'h0000_0000, 16'hFFFF, NPAGE);      // owner only
    issue(OP_DETACH, 8'd1, 32'h0000_0000, 16'h0000, 0);          // unlink head
    issue(OP_DETACH, 8'd2, 32'hFFFF_FFFF, 16'hFFFF, 0);          // list goes empty
    issue(OP_ATTACH, 8'd0, 32'h5555_5555, 16'hAAAA, 2);          // entry 1
    issue(OP_ATTACH, 8'd1, 32'h1234_5678, 16'h1234, 2);          // entry 2 behind 1
    issue(OP_DETACH, 8'd2, 32'h1234_5678, 16'h1234, NPAGE);      // frees 2, 1 still points at it
    // Attach on a head equal to the entry handed out: entry 2 links to itself
    issue(OP_ATTACH, 8'd2, 32'h0000_0009, 16'h0009, NPAGE);
    issue(OP_DETACH, 8'd2, 32'h0000_0007, 16'h0007, NPAGE);      // bounded walk, no match
    issue(OP_ATTACH, 8'd1, 32'h0000_0008, 16'h0008, 2);          // bounded walk, then link
    issue(OP_DETACH, 8'd1, 32'h0000_0008, 16'h0008, 2);          // unlink mid-list

    // Random phases, each with its own limit setting written while idle
    for (int ph = 0; ph < NPHASE; ph++) begin
      drain_all();
      if (PH_CFG[ph] == CFG_RANDOM) write_limit(LIM_W'($urandom_range(4, 255)));
      else write_limit(LIM_W'(PH_CFG[ph]));
      for (int k = 0; k < PH_ITEMS[ph]; k++) begin
        quiet = (k % 100) < 15;
        if (ph == 0 && k == 150) drain_all();
        random_item(PH_ATTACH[ph]);
      end
    end

    drain_all();
    repeat (TAIL) @(posedge clk);
    end_req <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[reverse_map_list_pool_core] OK");
    end else begin
      $display("[reverse_map_list_pool_core] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/rmlp_pkg.sv
design/rmlp_entry_mem.sv
design/rmlp_free_map.sv
design/reverse_map_list_pool_core.sv
test/rmap_checker.sv
test/tb_top.sv
